// ===== src/assert_macros.svh =====
// shared assertion macros for the splitter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SQLSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// trigger implies the consequence in the next cycle
`define SQLSS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/sqlss_pkg.sv =====
`timescale 1ns / 1ps

package sqlss_pkg;

  localparam int MaxDelim  = 8;
  localparam int HoldDepth = (MaxDelim > 3) ? MaxDelim : 3;
  localparam int CntW      = $clog2(HoldDepth + 1);

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [HoldDepth-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    CfgDelimBytes = 2'd0,
    CfgDelimLen   = 2'd1,
    CfgCondMode   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteSingle = 2'd1,
    QuoteDouble = 2'd2,
    QuoteBack   = 2'd3
  } quote_e;

  typedef struct packed {
    logic [63:0] delim_bytes;
    cnt_t        dlen;
    cnt_t        need;
    logic        cond_mode;
  } cfg_t;

  typedef struct packed {
    quote_e quote;
    logic   block;
    logic   line;
    logic   cond;
    logic   esc;
    logic   nonempty;
  } flags_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       statement_end;
  } result_t;

  typedef struct packed {
    logic       emit;
    result_t    r1;
    logic       pend_v;
    logic [7:0] pend_byte;
    cnt_t       consume;
    flags_t     flags;
  } dec_t;

endpackage

// ===== src/sqlss_stream_if.sv =====
`timescale 1ns / 1ps

interface sqlss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sqlss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       statement_end;
  logic       last_of_run;

  modport source (
    output valid, output out_byte, output byte_valid, output statement_end,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input statement_end,
    input last_of_run, output ready
  );
endinterface

// ===== src/sqlss_cfg.sv =====
`timescale 1ns / 1ps

module sqlss_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  output sqlss_pkg::cfg_t   cfg_o
);
  import sqlss_pkg::*;

  logic [63:0] delim_q, delim_d;
  logic [3:0]  len_q, len_d;
  logic        cmode_q, cmode_d;
  logic [3:0]  dl4;
  cnt_t        dl;

  always_comb begin
    delim_d = delim_q;
    len_d   = len_q;
    cmode_d = cmode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDelimBytes: delim_d = cfg_data_i;
        CfgDelimLen:   len_d   = cfg_data_i[3:0];
        CfgCondMode:   cmode_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= 64'd59;
      len_q   <= 4'd1;
      cmode_q <= 1'b1;
    end else begin
      delim_q <= delim_d;
      len_q   <= len_d;
      cmode_q <= cmode_d;
    end
  end

  // clamp length into 1..MaxDelim
  always_comb begin
    if (len_q == 4'd0) begin
      dl4 = 4'd1;
    end else if (len_q > 4'(MaxDelim)) begin
      dl4 = 4'(MaxDelim);
    end else begin
      dl4 = len_q;
    end
    dl = CntW'(dl4);
    cfg_o.delim_bytes = delim_q;
    cfg_o.dlen        = dl;
    cfg_o.need        = (dl > CntW'(3)) ? dl : CntW'(3);
    cfg_o.cond_mode   = cmode_q;
  end

endmodule

// ===== src/sqlss_decide.sv =====
`timescale 1ns / 1ps

module sqlss_decide (
  input  sqlss_pkg::win_t   win_i,
  input  sqlss_pkg::cnt_t   cnt_i,
  input  sqlss_pkg::flags_t flags_i,
  input  sqlss_pkg::cfg_t   cfg_i,
  output sqlss_pkg::dec_t   dec_o
);
  import sqlss_pkg::*;

  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChDash      = 8'h2d;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChStar      = 8'h2a;
  localparam logic [7:0] ChBang      = 8'h21;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChBtick     = 8'h60;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChCapN      = 8'h4e;

  function automatic quote_e quote_of(input logic [7:0] ch);
    quote_e q;
    case (ch)
      ChSquote: q = QuoteSingle;
      ChDquote: q = QuoteDouble;
      ChBtick:  q = QuoteBack;
      default:  q = QuoteNone;
    endcase
    return q;
  endfunction

  logic [7:0] c;
  logic       has1, has2;
  logic       slash_star, bang, star_slash, dash_dash;
  logic       hit, no_quote, cond;
  quote_e     q;

  always_comb begin
    c          = win_i[0];
    has1       = cnt_i > CntW'(1);
    has2       = cnt_i > CntW'(2);
    slash_star = has1 && c == ChSlash && win_i[1] == ChStar;
    bang       = has2 && win_i[2] == ChBang;
    star_slash = has1 && c == ChStar && win_i[1] == ChSlash;
    dash_dash  = has2 && c == ChDash && win_i[1] == ChDash && win_i[2] == ChSpace;
    no_quote   = flags_i.quote == QuoteNone;
    cond       = flags_i.cond && cfg_i.cond_mode;
    q          = quote_of(c);

    hit = cnt_i >= cfg_i.dlen;
    for (int i = 0; i < MaxDelim; i++) begin
      if (i < int'(cfg_i.dlen) && win_i[i] != cfg_i.delim_bytes[8*i +: 8]) begin
        hit = 1'b0;
      end
    end

    dec_o.emit             = 1'b1;
    dec_o.r1.out_byte      = c;
    dec_o.r1.byte_valid    = 1'b1;
    dec_o.r1.statement_end = 1'b0;
    dec_o.pend_v           = 1'b0;
    dec_o.pend_byte        = c;
    dec_o.consume          = CntW'(1);
    dec_o.flags            = flags_i;

    if (flags_i.esc) begin
      dec_o.flags.esc = 1'b0;
      if (!no_quote || c == ChCapN) begin
        dec_o.r1.out_byte = ChBackslash;
        dec_o.pend_v      = 1'b1;
      end
    end else if (flags_i.line) begin
      if (c == ChNewline) begin
        dec_o.flags.line = 1'b0;
      end
    end else if (!flags_i.block && c == ChBackslash) begin
      dec_o.flags.esc = 1'b1;
      dec_o.emit      = 1'b0;
    end else if (!flags_i.block && !cond && no_quote && hit) begin
      dec_o.r1.out_byte      = 8'h00;
      dec_o.r1.byte_valid    = 1'b0;
      dec_o.r1.statement_end = 1'b1;
      dec_o.consume          = cfg_i.dlen;
      dec_o.flags.nonempty   = 1'b0;
    end else if (!flags_i.block && no_quote && (c == ChHash || dash_dash)) begin
      dec_o.flags.line = 1'b1;
    end else if (no_quote && slash_star && !bang) begin
      dec_o.flags.block = 1'b1;
      dec_o.pend_v      = 1'b1;
      dec_o.pend_byte   = ChStar;
      dec_o.consume     = CntW'(2);
    end else if (cfg_i.cond_mode && !cond && no_quote && slash_star && bang) begin
      dec_o.flags.cond = 1'b1;
    end else if (cond && flags_i.block && star_slash) begin
      dec_o.flags.block = 1'b0;
    end else if (cond && no_quote && star_slash) begin
      dec_o.flags.cond = 1'b0;
    end else if (flags_i.block && star_slash) begin
      dec_o.flags.block = 1'b0;
      dec_o.pend_v      = 1'b1;
      dec_o.pend_byte   = ChSlash;
      dec_o.consume     = CntW'(2);
    end else begin
      if (q != QuoteNone && q == flags_i.quote) begin
        dec_o.flags.quote = QuoteNone;
      end else if (!flags_i.block && no_quote && q != QuoteNone) begin
        dec_o.flags.quote = q;
      end
    end

    if (dec_o.emit && dec_o.r1.byte_valid) begin
      dec_o.flags.nonempty = 1'b1;
    end
  end

endmodule

// ===== src/sqlss_out_stage.sv =====
`timescale 1ns / 1ps

module sqlss_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  sqlss_pkg::result_t res_i,
  input  logic               run_done_i,
  output logic               go_o,
  sqlss_out_if.source        out_o
);
  import sqlss_pkg::*;

  // one-deep staging so the last flag is known before the item leaves
  logic    stg_v_q, stg_v_d;
  logic    stg_final_q, stg_final_d;
  result_t stg_q, stg_d;
  logic    out_v_q, out_v_d;
  result_t out_q, out_d;
  logic    out_last_q, out_last_d;
  logic    out_free, push;

  always_comb begin
    out_free    = !out_v_q || out_o.ready;
    go_o        = out_free || !stg_v_q;
    push        = stg_v_q && out_free && (stg_final_q || res_valid_i);

    stg_v_d     = stg_v_q;
    stg_final_d = stg_final_q;
    stg_d       = stg_q;
    if (res_valid_i) begin
      stg_v_d     = 1'b1;
      stg_final_d = run_done_i;
      stg_d       = res_i;
    end else if (push) begin
      stg_v_d     = 1'b0;
      stg_final_d = 1'b0;
    end else if (run_done_i && stg_v_q) begin
      stg_final_d = 1'b1;
    end

    out_v_d    = out_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_d      = stg_q;
      out_last_d = stg_final_q;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q     <= 1'b0;
      stg_final_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      stg_v_q     <= stg_v_d;
      stg_final_q <= stg_final_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q      <= stg_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid         = out_v_q;
  assign out_o.out_byte      = out_q.out_byte;
  assign out_o.byte_valid    = out_q.byte_valid;
  assign out_o.statement_end = out_q.statement_end;
  assign out_o.last_of_run   = out_last_q;

endmodule

// ===== src/sql_statement_splitter_unit.sv =====
// SQL statement splitter: bytes enter on in_i (valid/ready), results leave
// on out_o (valid/ready). Each result carries a passed byte or a statement
// end; last_of_run marks the final result caused by one input item.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_data_i: index 0 is the
// delimiter bytes, 1 the delimiter length, 2 conditional comment mode.
// With the unit idle, an item waits in the input register and its first
// result then passes the staging and output registers. Throughput: one item
// per cycle while out_o.ready stays high and each item needs at most one
// window decision and yields at most one result. The single decide unit
// makes its window decisions one after another; the second byte of an escape
// pair or of a comment opener or closer goes out on its own. End of input
// adds a step that closes the statement, whether or not an end is sent.
// Reset clears the quote and comment flags and empties the look-ahead window;
// configuration returns to ';', length 1, conditional mode on.
// When the receiver stalls, the output register holds its result and one
// more result waits in the staging register; then the decide unit stops and
// in_i.ready drops once one more item waits in the input register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sql_statement_splitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqlss_in_if.sink    in_i,
  sqlss_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import sqlss_pkg::*;

  cfg_t       cfg;
  dec_t       dec;
  logic       go;

  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_eoi_q, in_eoi_d;
  logic       in_take;

  logic       act_q, act_d;
  logic       flush_q, flush_d;
  logic       pend_v_q, pend_v_d;
  logic [7:0] pend_q, pend_d;
  win_t       win_q, win_d;
  cnt_t       cnt_q, cnt_d;
  flags_t     flags_q, flags_d;

  win_t       wv;
  cnt_t       cv;
  cnt_t       cnt_left;
  logic       flushing, do_dec;
  logic       res_v, run_done;
  result_t    res;

  sqlss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // window view: held bytes, plus the new byte when an item that is not end of input starts
  always_comb begin
    wv = win_q;
    cv = cnt_q;
    if (!act_q && !in_eoi_q && cnt_q < CntW'(HoldDepth)) begin
      for (int i = 0; i < HoldDepth; i++) begin
        if (CntW'(i) == cnt_q) begin
          wv[i] = in_byte_q;
        end
      end
      cv = cnt_q + CntW'(1);
    end
  end

  sqlss_decide u_decide (
    .win_i   (wv),
    .cnt_i   (cv),
    .flags_i (flags_q),
    .cfg_i   (cfg),
    .dec_o   (dec)
  );

  always_comb begin
    flushing = act_q ? flush_q : in_eoi_q;
    do_dec   = flushing ? (cv != '0) : (cv >= cfg.need);
    cnt_left = cv - dec.consume;

    act_d    = act_q;
    flush_d  = flush_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    win_d    = win_q;
    cnt_d    = cnt_q;
    flags_d  = flags_q;
    in_take  = 1'b0;
    res_v    = 1'b0;
    res      = '0;
    run_done = 1'b0;

    if (go) begin
      if (pend_v_q) begin
        res_v          = 1'b1;
        res.out_byte   = pend_q;
        res.byte_valid = 1'b1;
        pend_v_d       = 1'b0;
        run_done       = !flush_q && cnt_q < cfg.need;
        act_d          = !run_done;
      end else if (act_q || in_v_q) begin
        in_take = !act_q;
        flush_d = flushing;
        if (do_dec) begin
          res_v    = dec.emit;
          res      = dec.r1;
          flags_d  = dec.flags;
          win_d    = wv >> {dec.consume, 3'b000};
          cnt_d    = cnt_left;
          pend_v_d = dec.pend_v;
          pend_d   = dec.pend_byte;
          run_done = !dec.pend_v && !flushing && cnt_left < cfg.need;
        end else if (flushing) begin
          res_v             = flags_q.nonempty;
          res.statement_end = 1'b1;
          flags_d           = '0;
          win_d             = wv;
          cnt_d             = cv;
          run_done          = 1'b1;
        end else begin
          win_d    = wv;
          cnt_d    = cv;
          run_done = 1'b1;
        end
        act_d = !run_done;
      end
    end

    in_v_d    = in_v_q;
    in_byte_d = in_byte_q;
    in_eoi_d  = in_eoi_q;
    if (in_i.valid && in_i.ready) begin
      in_v_d    = 1'b1;
      in_byte_d = in_i.in_byte;
      in_eoi_d  = in_i.end_of_input;
    end else if (in_take) begin
      in_v_d = 1'b0;
    end
  end

  assign in_i.ready = !in_v_q || in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      act_q    <= 1'b0;
      flush_q  <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      flags_q  <= '0;
    end else begin
      in_v_q   <= in_v_d;
      act_q    <= act_d;
      flush_q  <= flush_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      flags_q  <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_eoi_q  <= in_eoi_d;
    pend_q    <= pend_d;
    win_q     <= win_d;
  end

  sqlss_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_v),
    .res_i       (res),
    .run_done_i  (run_done),
    .go_o        (go),
    .out_o       (out_o)
  );

  `SQLSS_ASSERT(a_cnt_bound, cnt_q <= CntW'(HoldDepth), "window count above depth")
  `SQLSS_ASSERT(a_pend_active, !pend_v_q || act_q, "second byte pending outside a run")
  `SQLSS_ASSERT(a_esc_line, !(flags_q.esc && flags_q.line), "escape inside line comment")
  `SQLSS_ASSERT_NEXT(a_take_run, in_take && !run_done, act_q, "started item not kept active")

endmodule
